// ===== design/gsk_pkg.sv =====
// gsk_pkg: shared constants, types and helpers for the gap similarity k-mer check
// used by every file of the block; depends on nothing

package gsk_pkg;

  localparam int KMER_LEN  = 5;
  localparam int GAP_CAP   = 4096;
  localparam int LEN_BITS  = 24;
  localparam int BASE_BITS = 8;
  localparam int CFG_BITS  = 13;
  localparam int CNT_BITS  = 13;
  localparam int CFG_RESET = 4096;

  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  localparam logic [1:0] DEC_NONE = 2'd0;
  localparam logic [1:0] DEC_DIAG = 2'd1;
  localparam logic [1:0] DEC_KMER = 2'd2;

  localparam logic [2:0] CODE_A = 3'd0;
  localparam logic [2:0] CODE_C = 3'd1;
  localparam logic [2:0] CODE_G = 3'd2;
  localparam logic [2:0] CODE_T = 3'd3;
  localparam logic [2:0] CODE_N = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPD,
    ST_DECIDE,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic upd;
    logic clr;
  } merge_ctl_t;

  function automatic logic [2:0] base_code(input logic [BASE_BITS-1:0] ch);
    logic [2:0] c;
    case (ch)
      8'h41, 8'h61: c = CODE_A;
      8'h43, 8'h63: c = CODE_C;
      8'h47, 8'h67: c = CODE_G;
      8'h54, 8'h74: c = CODE_T;
      default:      c = CODE_N;
    endcase
    return c;
  endfunction

endpackage

// ===== design/gsk_if.sv =====
// gsk_in_if / gsk_out_if: valid-ready channels for base beats and result beats
// depends on gsk_pkg

interface gsk_in_if;
  logic                          valid;
  logic                          ready;
  logic [gsk_pkg::BASE_BITS-1:0] query_base;
  logic                          query_valid;
  logic [gsk_pkg::BASE_BITS-1:0] ref_base;
  logic                          ref_valid;
  logic                          gap_end;

  modport source (output valid, query_base, query_valid, ref_base, ref_valid, gap_end,
                  input ready);
  modport sink   (input valid, query_base, query_valid, ref_base, ref_valid, gap_end,
                  output ready);
endinterface

interface gsk_out_if #(parameter int LEN_BITS = gsk_pkg::LEN_BITS);
  logic                         valid;
  logic                         ready;
  logic                         similar;
  logic [1:0]                   decided_by;
  logic [LEN_BITS-1:0]          matched_bases;
  logic [gsk_pkg::CNT_BITS-1:0] shared_kmers;

  modport source (output valid, similar, decided_by, matched_bases, shared_kmers,
                  input ready);
  modport sink   (input valid, similar, decided_by, matched_bases, shared_kmers,
                  output ready);
endinterface

// ===== design/gsk_lane.sv =====
// gsk_lane: one sequence side - length, rolling 2-bit window and run of ACGT bases
// depends on gsk_pkg

module gsk_lane #(
  parameter int KMER_LEN = gsk_pkg::KMER_LEN,
  parameter int LEN_BITS = gsk_pkg::LEN_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic                  clear,
  input  logic                  base_valid,
  input  logic [2:0]            code,
  output logic [LEN_BITS-1:0]   len,
  output logic                  kmer_fire,
  output logic [2*KMER_LEN-1:0] kmer_id
);

  localparam int IW    = 2 * KMER_LEN;
  localparam int RUN_W = $clog2(KMER_LEN + 1);
  localparam logic [RUN_W-1:0] RUN_FULL = RUN_W'(KMER_LEN);

  logic [LEN_BITS-1:0] len_r, len_nxt;
  logic [IW-1:0]       win_r, win_nxt;
  logic [RUN_W-1:0]    run_r, run_nxt;
  logic                fire_r, fire_nxt;
  logic                acgt;

  assign acgt = (code != gsk_pkg::CODE_N);

  always_comb begin
    len_nxt  = len_r;
    win_nxt  = win_r;
    run_nxt  = run_r;
    fire_nxt = fire_r;
    if (accept) begin
      fire_nxt = 1'b0;
      if (base_valid) begin
        if (len_r != '1) len_nxt = len_r + 1'b1;
        if (acgt) begin
          win_nxt = {win_r[IW-3:0], code[1:0]};
          run_nxt = (run_r < RUN_FULL) ? run_r + 1'b1 : RUN_FULL;
          fire_nxt = (run_nxt == RUN_FULL);
        end else begin
          run_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      len_r  <= '0;
      win_r  <= '0;
      run_r  <= '0;
      fire_r <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      win_r  <= win_nxt;
      run_r  <= run_nxt;
      fire_r <= fire_nxt;
    end
  end

  assign len       = len_r;
  assign kmer_fire = fire_r;
  assign kmer_id   = win_r;

endmodule

// ===== design/gsk_merge.sv =====
// gsk_merge: query and reference k-mer count tables, shared count and clear sweep
// depends on gsk_pkg

module gsk_merge #(
  parameter int KMER_LEN = gsk_pkg::KMER_LEN
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gsk_pkg::merge_ctl_t           ctl,
  input  logic                          q_fire,
  input  logic [2*KMER_LEN-1:0]         q_id,
  input  logic                          r_fire,
  input  logic [2*KMER_LEN-1:0]         r_id,
  output logic [gsk_pkg::CNT_BITS-1:0]  shared,
  output logic                          clr_done
);

  localparam int IW    = 2 * KMER_LEN;
  localparam int DEPTH = 1 << IW;
  localparam int CB    = gsk_pkg::CNT_BITS;

  logic [CB-1:0] q_mem [DEPTH];
  logic [CB-1:0] r_mem [DEPTH];

  logic [CB-1:0] q_at_q, q_at_r, r_at_q, r_at_r;
  logic [IW-1:0] clr_addr_r;
  logic [CB-1:0] shared_r, shared_nxt;

  logic          q_add, r_add, q_sh, r_sh;
  logic [CB-1:0] rb_eff;
  logic [CB:0]   sum;

  // query k-mer goes in first, so the reference side sees its updated count
  always_comb begin
    q_add  = q_fire && (q_at_q != gsk_pkg::CNT_MAX);
    q_sh   = q_add && (q_at_q < r_at_q);
    rb_eff = (q_add && (q_id == r_id)) ? q_at_r + 1'b1 : q_at_r;
    r_add  = r_fire && (r_at_r != gsk_pkg::CNT_MAX);
    r_sh   = r_add && (r_at_r < rb_eff);
    sum    = {1'b0, shared_r} + (CB+1)'(q_sh) + (CB+1)'(r_sh);
    shared_nxt = shared_r;
    if (ctl.clr) begin
      shared_nxt = '0;
    end else if (ctl.upd) begin
      shared_nxt = (sum > {1'b0, gsk_pkg::CNT_MAX}) ? gsk_pkg::CNT_MAX : sum[CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      q_mem[clr_addr_r] <= '0;
      r_mem[clr_addr_r] <= '0;
    end else if (ctl.upd) begin
      if (q_add) q_mem[q_id] <= q_at_q + 1'b1;
      if (r_add) r_mem[r_id] <= r_at_r + 1'b1;
    end
    q_at_q <= q_mem[q_id];
    q_at_r <= q_mem[r_id];
    r_at_q <= r_mem[q_id];
    r_at_r <= r_mem[r_id];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      shared_r   <= '0;
    end else begin
      if (ctl.clr) clr_addr_r <= clr_addr_r + 1'b1;
      shared_r <= shared_nxt;
    end
  end

  assign clr_done = ctl.clr && (clr_addr_r == '1);
  assign shared   = shared_r;

endmodule

// ===== design/gap_similarity_kmer_check.sv =====
// gap_similarity_kmer_check: top level - sequencer, diagonal match count, verdict
// depends on gsk_pkg, gsk_if, gsk_lane, gsk_merge

// Streams a query gap and a reference gap, one base of each per beat, and on the
// beat marked gap_end returns one verdict beat. An ordinary beat passes the
// steps accept, k-mer table read, table read-modify-write; the two table updates
// are one read-modify-write per table, both in the same step. The gap_end beat then
// goes to a decide step that forms the verdict (held while the previous result is
// not taken) and a clear sweep over all 4^KMER_LEN entries (1024 at the default) of
// both count tables, one entry a cycle, during which no beat is accepted. The same
// sweep runs after reset. Configuration writes are taken at any time.

module gap_similarity_kmer_check #(
  parameter int KMER_LEN = gsk_pkg::KMER_LEN,
  parameter int GAP_CAP  = gsk_pkg::GAP_CAP,
  parameter int LEN_BITS = gsk_pkg::LEN_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  gsk_in_if.sink                        in_ch,
  gsk_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [gsk_pkg::CFG_BITS-1:0]  cfg_wdata
);

  localparam int IW  = 2 * KMER_LEN;
  localparam int CB  = gsk_pkg::CNT_BITS;
  localparam int FB  = gsk_pkg::CFG_BITS;
  localparam int CW  = LEN_BITS + FB;
  localparam int KW  = LEN_BITS + CB + 4;
  localparam logic [16:0] GAP17 = 17'(GAP_CAP);
  localparam logic [FB-1:0] MSG_RESET =
    FB'((gsk_pkg::CFG_RESET > GAP_CAP) ? GAP_CAP : gsk_pkg::CFG_RESET);

  gsk_pkg::state_t     state_r, state_nxt;
  gsk_pkg::merge_ctl_t ctl;

  logic [FB-1:0]       msg_r;
  logic [LEN_BITS-1:0] match_r, match_nxt;
  logic                end_r;

  logic                out_valid_r, sim_r;
  logic [1:0]          by_r;
  logic [LEN_BITS-1:0] matched_r;
  logic [CB-1:0]       shared_out_r;

  logic                accept, load, lane_clear, clr_done;
  logic [2:0]          qc, rc;
  logic [LEN_BITS-1:0] qlen, rlen;
  logic                q_fire, r_fire;
  logic [IW-1:0]       q_id, r_id;
  logic [CB-1:0]       shared;
  logic                diag_ok, seed_ok, kmer_ok;
  logic [1:0]          by_nxt;

  assign accept = in_ch.valid && in_ch.ready;
  assign qc     = gsk_pkg::base_code(in_ch.query_base);
  assign rc     = gsk_pkg::base_code(in_ch.ref_base);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gsk_pkg::ST_IDLE:   if (accept) state_nxt = gsk_pkg::ST_READ;
      gsk_pkg::ST_READ:   state_nxt = gsk_pkg::ST_UPD;
      gsk_pkg::ST_UPD:    state_nxt = end_r ? gsk_pkg::ST_DECIDE : gsk_pkg::ST_IDLE;
      gsk_pkg::ST_DECIDE: if (!out_valid_r || out_ch.ready) state_nxt = gsk_pkg::ST_CLEAR;
      gsk_pkg::ST_CLEAR:  if (clr_done) state_nxt = gsk_pkg::ST_IDLE;
      default:            state_nxt = gsk_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready = 1'b0;
    ctl.upd     = 1'b0;
    ctl.clr     = 1'b0;
    load        = 1'b0;
    case (state_r)
      gsk_pkg::ST_IDLE:   in_ch.ready = 1'b1;
      gsk_pkg::ST_READ:   ;
      gsk_pkg::ST_UPD:    ctl.upd = 1'b1;
      gsk_pkg::ST_DECIDE: load = !out_valid_r || out_ch.ready;
      gsk_pkg::ST_CLEAR:  ctl.clr = 1'b1;
      default:            ;
    endcase
  end

  assign lane_clear = load;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= gsk_pkg::ST_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    match_nxt = match_r;
    if (accept && in_ch.query_valid && in_ch.ref_valid &&
        (qc == rc || qc == gsk_pkg::CODE_N || rc == gsk_pkg::CODE_N) && match_r != '1)
      match_nxt = match_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || lane_clear) match_r <= '0;
    else                      match_r <= match_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) end_r <= in_ch.gap_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_r <= MSG_RESET;
    end else if (cfg_we) begin
      msg_r <= ({4'b0, cfg_wdata} > GAP17) ? FB'(GAP_CAP) : cfg_wdata;
    end
  end

  gsk_lane #(.KMER_LEN(KMER_LEN), .LEN_BITS(LEN_BITS)) u_lane_q (
    .clk(clk), .rst_n(rst_n), .accept(accept), .clear(lane_clear),
    .base_valid(in_ch.query_valid), .code(qc),
    .len(qlen), .kmer_fire(q_fire), .kmer_id(q_id)
  );

  gsk_lane #(.KMER_LEN(KMER_LEN), .LEN_BITS(LEN_BITS)) u_lane_r (
    .clk(clk), .rst_n(rst_n), .accept(accept), .clear(lane_clear),
    .base_valid(in_ch.ref_valid), .code(rc),
    .len(rlen), .kmer_fire(r_fire), .kmer_id(r_id)
  );

  gsk_merge #(.KMER_LEN(KMER_LEN)) u_merge (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .q_fire(q_fire), .q_id(q_id), .r_fire(r_fire), .r_id(r_id),
    .shared(shared), .clr_done(clr_done)
  );

  // verdict
  always_comb begin
    diag_ok = (qlen == rlen) && ({match_r, 1'b0} >= {1'b0, qlen});
    seed_ok = (CW'(qlen) <= CW'(msg_r)) && (CW'(rlen) <= CW'(msg_r));
    kmer_ok = (KW'(shared) * KW'(10)) > (KW'(qlen) + KW'(rlen));
    if (diag_ok)                 by_nxt = gsk_pkg::DEC_DIAG;
    else if (seed_ok && kmer_ok) by_nxt = gsk_pkg::DEC_KMER;
    else                         by_nxt = gsk_pkg::DEC_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sim_r        <= (by_nxt != gsk_pkg::DEC_NONE);
      by_r         <= by_nxt;
      matched_r    <= match_r;
      shared_out_r <= shared;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.similar       = sim_r;
  assign out_ch.decided_by    = by_r;
  assign out_ch.matched_bases = matched_r;
  assign out_ch.shared_kmers  = shared_out_r;

endmodule

// ===== design/gsk_checker.sv =====
// gsk_checker: port-level assertions for gap_similarity_kmer_check, with its bind
// depends on gsk_pkg and the top level's ports

module gsk_checker #(
  parameter int LEN_BITS = gsk_pkg::LEN_BITS
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         similar,
  input logic [1:0]                   decided_by,
  input logic [LEN_BITS-1:0]          matched_bases,
  input logic [gsk_pkg::CNT_BITS-1:0] shared_kmers
);

  // a result beat waits until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(matched_bases) && $stable(shared_kmers)
                                && $stable(decided_by))
    else $error("result payload changed while stalled");

  // one beat in flight: no accept right after an accept
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (similar == (decided_by != gsk_pkg::DEC_NONE)))
    else $error("verdict and deciding test disagree");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (decided_by == gsk_pkg::DEC_NONE || decided_by == gsk_pkg::DEC_DIAG ||
                   decided_by == gsk_pkg::DEC_KMER))
    else $error("bad decided_by code");

endmodule

bind gap_similarity_kmer_check gsk_checker #(.LEN_BITS(LEN_BITS)) u_gsk_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .similar(out_ch.similar), .decided_by(out_ch.decided_by),
  .matched_bases(out_ch.matched_bases), .shared_kmers(out_ch.shared_kmers)
);

// ===== dv/tb_gsk_scoreboard.sv =====
// gap verdict scoreboard: predicts gap_similarity_kmer_check verdicts from accepted beats
// depends on gsk_pkg

class gap_verdict_board;
  typedef struct packed {
    logic        similar;
    logic [1:0]  decided_by;
    logic [23:0] matched;
    logic [12:0] shared;
  } verdict_t;

  logic [12:0] seed_limit;
  logic [9:0]  q_win, r_win;
  int unsigned q_run, r_run;
  logic [12:0] q_tab [1024];
  logic [12:0] r_tab [1024];
  logic [23:0] q_len, r_len, match_cnt;
  logic [12:0] shared;
  verdict_t    pending [$];
  int unsigned errors;
  int unsigned verdicts;

  function new();
    seed_limit = 13'(gsk_pkg::CFG_RESET);
    errors = 0;
    verdicts = 0;
    clear_gap();
  endfunction

  function void clear_gap();
    q_win = '0; r_win = '0; q_run = 0; r_run = 0;
    q_len = '0; r_len = '0; match_cnt = '0; shared = '0;
    foreach (q_tab[i]) begin
      q_tab[i] = '0;
      r_tab[i] = '0;
    end
  endfunction

  function void set_limit(logic [12:0] v);
    seed_limit = (v > 13'(gsk_pkg::GAP_CAP)) ? 13'(gsk_pkg::GAP_CAP) : v;
  endfunction

  function logic [2:0] code_of(logic [7:0] ch);
    case (ch)
      "A", "a": return gsk_pkg::CODE_A;
      "C", "c": return gsk_pkg::CODE_C;
      "G", "g": return gsk_pkg::CODE_G;
      "T", "t": return gsk_pkg::CODE_T;
      default:  return gsk_pkg::CODE_N;
    endcase
  endfunction

  function void bump_shared();
    if (shared != gsk_pkg::CNT_MAX) shared++;
  endfunction

  function void note_beat(logic [7:0] qb, logic qv, logic [7:0] rb, logic rv, logic last);
    logic [2:0] qc, rc;
    verdict_t v;
    qc = code_of(qb);
    rc = code_of(rb);
    if (qv && rv && (qc == rc || qc == gsk_pkg::CODE_N || rc == gsk_pkg::CODE_N))
      if (match_cnt != '1) match_cnt++;
    if (qv) begin
      if (q_len != '1) q_len++;
      if (qc == gsk_pkg::CODE_N) q_run = 0;
      else begin
        q_win = {q_win[7:0], qc[1:0]};
        if (q_run < 5) q_run++;
        if (q_run == 5 && q_tab[q_win] != gsk_pkg::CNT_MAX) begin
          if (q_tab[q_win] < r_tab[q_win]) bump_shared();
          q_tab[q_win]++;
        end
      end
    end
    if (rv) begin
      if (r_len != '1) r_len++;
      if (rc == gsk_pkg::CODE_N) r_run = 0;
      else begin
        r_win = {r_win[7:0], rc[1:0]};
        if (r_run < 5) r_run++;
        if (r_run == 5 && r_tab[r_win] != gsk_pkg::CNT_MAX) begin
          if (r_tab[r_win] < q_tab[r_win]) bump_shared();
          r_tab[r_win]++;
        end
      end
    end
    if (!last) return;
    v.matched = match_cnt;
    v.shared = shared;
    if (q_len == r_len && 2 * longint'(match_cnt) >= longint'(q_len)) begin
      v.similar = 1'b1; v.decided_by = gsk_pkg::DEC_DIAG;
    end else if (q_len <= seed_limit && r_len <= seed_limit &&
                 10 * longint'(shared) > longint'(q_len) + longint'(r_len)) begin
      v.similar = 1'b1; v.decided_by = gsk_pkg::DEC_KMER;
    end else begin
      v.similar = 1'b0; v.decided_by = gsk_pkg::DEC_NONE;
    end
    pending = {pending, v};
    clear_gap();
  endfunction

  function void check_verdict(verdict_t got);
    verdict_t exp;
    verdicts++;
    if (pending.size() == 0) begin
      $display("%0t: unexpected verdict beat %p", $time, got);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (got.similar !== exp.similar) begin
      $display("%0t: similar exp %0d got %0d", $time, exp.similar, got.similar);
      errors++;
    end
    if (got.decided_by !== exp.decided_by) begin
      $display("%0t: decided_by exp %0d got %0d", $time, exp.decided_by, got.decided_by);
      errors++;
    end
    if (got.matched !== exp.matched) begin
      $display("%0t: matched_bases exp %0d got %0d", $time, exp.matched, got.matched);
      errors++;
    end
    if (got.shared !== exp.shared) begin
      $display("%0t: shared_kmers exp %0d got %0d", $time, exp.shared, got.shared);
      errors++;
    end
  endfunction
endclass

// ===== dv/tb_gap_similarity_kmer_check.sv =====
// testbench top for gap_similarity_kmer_check: directed and random gap pairs,
// random stalls, seed-gap limit sweeps; depends on gsk_pkg, gsk_if, the scoreboard and the design

module tb_gap_similarity_kmer_check;

  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [gsk_pkg::CFG_BITS-1:0] cfg_wdata = '0;
  logic src_busy_free = 1'b0;
  logic snk_busy_free = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned beats_sent = 0;

  gsk_in_if  in_ch();
  gsk_out_if out_ch();
  gap_verdict_board board;

  gap_similarity_kmer_check dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.query_base = '0;
    in_ch.query_valid = 1'b0;
    in_ch.ref_base = '0;
    in_ch.ref_valid = 1'b0;
    in_ch.gap_end = 1'b0;
    out_ch.ready = 1'b0;
    board = new();
  end

  // result side: random stalls, sampled at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        board.check_verdict({out_ch.similar, out_ch.decided_by,
                             out_ch.matched_bases, out_ch.shared_kmers});
      out_ch.ready <= snk_busy_free || ($urandom_range(99) >= 8);
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("gap_similarity_kmer_check: mismatch");
      $finish;
    end
  end

  function automatic logic [7:0] pick_base(int unsigned n_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < n_pct) return ($urandom_range(3) == 0) ? "N" : 8'($urandom);
    case ($urandom_range(7))
      0: return "A"; 1: return "C"; 2: return "G"; 3: return "T";
      4: return "a"; 5: return "c"; 6: return "g"; default: return "t";
    endcase
  endfunction

  // valid stays up after the beat; the next beat or an idle cycle replaces it
  task automatic send_beat(logic [7:0] qb, logic qv, logic [7:0] rb, logic rv, logic last);
    while (!src_busy_free && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.query_base <= qb;
    in_ch.query_valid <= qv;
    in_ch.ref_base <= rb;
    in_ch.ref_valid <= rv;
    in_ch.gap_end <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_beat(qb, qv, rb, rv, last);
    beats_sent++;
  endtask

  // gap pair with a related reference (copy with mutations) or unrelated
  task automatic send_gap(int unsigned qlen, int unsigned rlen, bit related, int unsigned n_pct);
    logic [7:0] q [$];
    logic [7:0] r;
    int unsigned n;
    n = (qlen > rlen) ? qlen : rlen;
    for (int i = 0; i < n; i++) q = {q, pick_base(n_pct)};
    for (int i = 0; i < n; i++) begin
      r = (related && $urandom_range(9) != 0) ? q[i] : pick_base(n_pct);
      send_beat(q[i], i < qlen, r, i < rlen, i == n - 1);
    end
    if (n == 0) send_beat(8'($urandom), 1'b0, 8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain_and_config(logic [gsk_pkg::CFG_BITS-1:0] v);
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    board.set_limit(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty gap, one-sided beats, all-N, repeats, unequal lengths
    send_beat("A", 1'b0, "C", 1'b0, 1'b1);
    send_beat(8'hFF, 1'b1, 8'h00, 1'b1, 1'b1);
    send_beat("A", 1'b1, "T", 1'b1, 1'b1);
    for (int i = 0; i < 8; i++) send_beat("a", 1'b1, "A", 1'b1, i == 7);
    for (int i = 0; i < 7; i++) send_beat("C", 1'b1, "G", i < 3, i == 6);
    for (int i = 0; i < 12; i++)
      send_beat(i == 5 ? "N" : "G", 1'b1, i == 2 ? 8'h80 : "g", 1'b1, i == 11);
    send_beat(8'h7F, 1'b1, "t", 1'b0, 1'b1);

    drain_and_config('1);      // above the cap
    for (int g = 0; g < 6; g++) send_gap($urandom_range(4, 20), $urandom_range(4, 20), g[0], 5);
    drain_and_config('0);
    for (int g = 0; g < 6; g++) send_gap($urandom_range(0, 20), $urandom_range(0, 20), 1, 5);
    drain_and_config(13'd12);
    for (int g = 0; g < 8; g++) send_gap($urandom_range(6, 18), $urandom_range(6, 18), 1, 3);
    drain_and_config(13'(gsk_pkg::GAP_CAP));

    // random part, with one stretch of no stalls at all
    while (beats_sent < 600) begin
      src_busy_free <= (beats_sent > 300 && beats_sent < 420);
      snk_busy_free <= (beats_sent > 300 && beats_sent < 420);
      case ($urandom_range(9))
        0: send_gap($urandom_range(0, 3), $urandom_range(0, 3), 0, 30);
        1, 2: send_gap($urandom_range(5, 25), $urandom_range(5, 25), 0, 10);
        default: begin
          int unsigned l;
          l = $urandom_range(5, 30);
          send_gap(l, ($urandom_range(3) == 0) ? l + $urandom_range(1, 3) : l, 1, 5);
        end
      endcase
    end
    in_ch.valid <= 1'b0;
    src_busy_free <= 1'b0;
    snk_busy_free <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d base beats and %0d verdicts over four seed-gap limits",
             beats_sent, board.verdicts);
    if (board.errors == 0)
      $display("gap_similarity_kmer_check: match");
    else
      $display("gap_similarity_kmer_check: mismatch");
    $finish;
  end
endmodule
